FILE: sv/gflsu_pkg.sv
// ----------------------------------------------------------------------------
// gflsu_pkg: shared types and constants of the grouped first/last select unit
// Holds the sizes, the operation and register codes, the control state
// and the structs that travel between the modules.
// ----------------------------------------------------------------------------
package gflsu_pkg;

   // Sizes
   localparam int MAX_GROUPS = 1024;
   localparam int GROUP_BITS = $clog2(MAX_GROUPS);
   localparam int COUNT_BITS = 11;
   localparam int VALUE_BITS = 64;
   localparam int ADDR_BITS  = 4;
   localparam int DATA_BITS  = 32;

   localparam logic [COUNT_BITS-1:0] GROUPS_RESET = COUNT_BITS'(MAX_GROUPS);
   localparam logic [GROUP_BITS-1:0] LAST_GROUP   = GROUP_BITS'(MAX_GROUPS - 1);

   // Item operation codes
   typedef enum logic [1:0] {
      OP_ACCUM,
      OP_READ,
      OP_CLEAR
   } op_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      REG_SELECT_LAST,
      REG_SKIP_MISSING,
      REG_GROUPS_IN_USE
   } reg_index_type;

   // Control state: clearing pass over the entry memory or normal running
   typedef enum logic {
      ST_CLEAR,
      ST_RUN
   } state_type;

   // Configuration as seen by the datapath
   typedef struct packed {
      logic                  select_last;
      logic                  skip_missing;
      logic [COUNT_BITS-1:0] groups_in_use;
   } cfg_type;

   // One stored group entry
   typedef struct packed {
      logic                  found;
      logic                  missing;
      logic [VALUE_BITS-1:0] value;
   } entry_type;

   // One input item
   typedef struct packed {
      logic [1:0]            op;
      logic [GROUP_BITS-1:0] group_index;
      logic [VALUE_BITS-1:0] sample_value;
      logic                  sample_missing;
   } item_type;

   // One result item
   typedef struct packed {
      logic [VALUE_BITS-1:0] entry_value;
      logic                  entry_missing;
      logic                  entry_found;
      logic                  group_error;
   } rsp_type;

endpackage

FILE: sv/gflsu_csr.sv
// ----------------------------------------------------------------------------
// gflsu_csr: configuration registers
// APB-style register file with select_last, skip_missing and groups_in_use.
// ----------------------------------------------------------------------------
module gflsu_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [gflsu_pkg::ADDR_BITS-1:0]   paddr,
   input  logic [gflsu_pkg::DATA_BITS-1:0]   pwdata,
   output logic [gflsu_pkg::DATA_BITS-1:0]   prdata,
   output logic                              pready,
   output gflsu_pkg::cfg_type                cfg
);

   logic                               select_last_ff;
   logic                               skip_missing_ff;
   logic [gflsu_pkg::COUNT_BITS-1:0]   groups_in_use_ff;
   logic                               wr_hit;
   logic [1:0]                         reg_index;

   assign pready    = 1'b1;
   assign reg_index = paddr[3:2];
   assign wr_hit    = psel & penable & pwrite;

   // Write registers on the access cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         select_last_ff   <= 1'b0;
         skip_missing_ff  <= 1'b0;
         groups_in_use_ff <= gflsu_pkg::GROUPS_RESET;
      end else if (wr_hit) begin
         case (reg_index)
            gflsu_pkg::REG_SELECT_LAST:   select_last_ff   <= pwdata[0];
            gflsu_pkg::REG_SKIP_MISSING:  skip_missing_ff  <= pwdata[0];
            gflsu_pkg::REG_GROUPS_IN_USE: groups_in_use_ff <= pwdata[gflsu_pkg::COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      prdata = '0;
      case (reg_index)
         gflsu_pkg::REG_SELECT_LAST:   prdata[0] = select_last_ff;
         gflsu_pkg::REG_SKIP_MISSING:  prdata[0] = skip_missing_ff;
         gflsu_pkg::REG_GROUPS_IN_USE: prdata[gflsu_pkg::COUNT_BITS-1:0] = groups_in_use_ff;
         default: ;
      endcase
   end

   assign cfg.select_last   = select_last_ff;
   assign cfg.skip_missing  = skip_missing_ff;
   assign cfg.groups_in_use = groups_in_use_ff;

endmodule

FILE: sv/gflsu_entry_ram.sv
// ----------------------------------------------------------------------------
// gflsu_entry_ram: group entry memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module gflsu_entry_ram (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [gflsu_pkg::GROUP_BITS-1:0]  wr_addr,
   input  gflsu_pkg::entry_type              wr_data,
   input  logic                              rd_en,
   input  logic [gflsu_pkg::GROUP_BITS-1:0]  rd_addr,
   output gflsu_pkg::entry_type              rd_data
);

   gflsu_pkg::entry_type mem [gflsu_pkg::MAX_GROUPS];
   gflsu_pkg::entry_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, old data on a same-address collision
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/gflsu_update.sv
// ----------------------------------------------------------------------------
// gflsu_update: entry update and result build
// Decides the store for an accumulate item, drops found on a clear item
// and forms the result from the entry after the step.
// ----------------------------------------------------------------------------
module gflsu_update (
   input  gflsu_pkg::cfg_type    cfg,
   input  gflsu_pkg::item_type   item,
   input  gflsu_pkg::entry_type  cur,
   output logic                  wr_en,
   output gflsu_pkg::entry_type  wr_data,
   output gflsu_pkg::rsp_type    rsp
);

   logic                 err;
   gflsu_pkg::entry_type nxt;

   always_comb begin
      err     = {1'b0, item.group_index} >= cfg.groups_in_use;
      nxt     = cur;
      wr_en   = 1'b0;

      // Store on accumulate: first mode only into an empty group
      case (item.op)
         gflsu_pkg::OP_ACCUM: begin
            if (!err && !(cfg.skip_missing && item.sample_missing) &&
                (cfg.select_last || !cur.found)) begin
               wr_en       = 1'b1;
               nxt.found   = 1'b1;
               nxt.missing = item.sample_missing;
               nxt.value   = item.sample_value;
            end
         end
         gflsu_pkg::OP_CLEAR: nxt.found = 1'b0;
         default: ;
      endcase
      wr_data = nxt;

      // Report an empty or bad group as value zero, missing
      if (err || !nxt.found) begin
         rsp.entry_value   = '0;
         rsp.entry_missing = 1'b1;
         rsp.entry_found   = 1'b0;
      end else begin
         rsp.entry_value   = nxt.value;
         rsp.entry_missing = nxt.missing;
         rsp.entry_found   = 1'b1;
      end
      rsp.group_error = err;
   end

endmodule

FILE: sv/grouped_first_last_select_unit.sv
// ----------------------------------------------------------------------------
// grouped_first_last_select_unit: per-group first or last value selection
// Keeps value, missing mark and found bit per group in one memory and
// updates it read-modify-write, one item per cycle unless the input is stalled.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  op, group_index, sample_value,
//                                             sample_missing
//   rsp_      out        rsp_valid/rsp_stall  entry_value, entry_missing,
//                                             entry_found, group_error
//   csr       in/out     psel/penable/pready  paddr, pwdata, prdata
//
// One item per cycle sustained while no stall or clearing pass holds the input;
// the entry is read as the item enters the update stage, and the result is
// registered in the output register when that stage moves on. A same-group item
// right behind another takes the written entry. A clear item is followed by a
// clearing pass over all MAX_GROUPS (1024) entries; reset starts the same pass.
// No item is accepted during the pass.
// A stalled result holds the update stage; the input stalls behind it.
// ----------------------------------------------------------------------------
module grouped_first_last_select_unit (
   input  logic                              clock,
   input  logic                              reset,
   // input channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_op,
   input  logic [gflsu_pkg::GROUP_BITS-1:0]  req_group_index,
   input  logic signed [gflsu_pkg::VALUE_BITS-1:0] req_sample_value,
   input  logic                              req_sample_missing,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [gflsu_pkg::VALUE_BITS-1:0] rsp_entry_value,
   output logic                              rsp_entry_missing,
   output logic                              rsp_entry_found,
   output logic                              rsp_group_error,
   // configuration port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [gflsu_pkg::ADDR_BITS-1:0]   paddr,
   input  logic [gflsu_pkg::DATA_BITS-1:0]   pwdata,
   output logic [gflsu_pkg::DATA_BITS-1:0]   prdata,
   output logic                              pready
);

   gflsu_pkg::cfg_type                cfg;
   gflsu_pkg::state_type              state_ff, state_in;
   logic [gflsu_pkg::GROUP_BITS-1:0]  clr_cnt_ff, clr_cnt_in;

   logic                              accept;
   logic                              s1_advance;
   logic                              s1_valid_ff;
   gflsu_pkg::item_type               s1_item_ff;
   logic                              s1_fwd_ff;
   gflsu_pkg::entry_type              fwd_word_ff;

   gflsu_pkg::entry_type              rd_data;
   gflsu_pkg::entry_type              cur;
   logic                              upd_wr_en;
   gflsu_pkg::entry_type              upd_wr_data;
   gflsu_pkg::rsp_type                upd_rsp;

   logic                              ram_wr_en;
   logic [gflsu_pkg::GROUP_BITS-1:0]  ram_wr_addr;
   gflsu_pkg::entry_type              ram_wr_data;

   logic                              rsp_valid_ff;
   gflsu_pkg::rsp_type                rsp_ff;

   gflsu_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Handshake: the update stage moves on when the output register frees
   assign s1_advance = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != gflsu_pkg::ST_RUN) ||
                       (s1_valid_ff && (!s1_advance ||
                        s1_item_ff.op == gflsu_pkg::OP_CLEAR));
   assign accept     = req_valid && !req_stall;

   // Clearing pass state machine
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= gflsu_pkg::ST_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      case (state_ff)
         gflsu_pkg::ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == gflsu_pkg::LAST_GROUP) begin
               state_in = gflsu_pkg::ST_RUN;
            end
         end
         gflsu_pkg::ST_RUN: begin
            if (s1_valid_ff && s1_advance && s1_item_ff.op == gflsu_pkg::OP_CLEAR) begin
               state_in   = gflsu_pkg::ST_CLEAR;
               clr_cnt_in = '0;
            end
         end
         default: state_in = gflsu_pkg::ST_CLEAR;
      endcase
   end

   // Memory write: clearing pass or update stage
   always_comb begin
      if (state_ff == gflsu_pkg::ST_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_cnt_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = s1_valid_ff && s1_advance && upd_wr_en;
         ram_wr_addr = s1_item_ff.group_index;
         ram_wr_data = upd_wr_data;
      end
   end

   gflsu_entry_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (req_group_index),
      .rd_data (rd_data)
   );

   // Update stage: capture the item and note a write to the same group
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff.op             <= req_op;
         s1_item_ff.group_index    <= req_group_index;
         s1_item_ff.sample_value   <= req_sample_value;
         s1_item_ff.sample_missing <= req_sample_missing;
         s1_fwd_ff                 <= ram_wr_en && (ram_wr_addr == req_group_index);
         fwd_word_ff               <= ram_wr_data;
      end
   end

   assign cur = s1_fwd_ff ? fwd_word_ff : rd_data;

   gflsu_update u_update (
      .cfg     (cfg),
      .item    (s1_item_ff),
      .cur     (cur),
      .wr_en   (upd_wr_en),
      .wr_data (upd_wr_data),
      .rsp     (upd_rsp)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_advance) begin
         rsp_ff <= upd_rsp;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_entry_value   = rsp_ff.entry_value;
   assign rsp_entry_missing = rsp_ff.entry_missing;
   assign rsp_entry_found   = rsp_ff.entry_found;
   assign rsp_group_error   = rsp_ff.group_error;

`ifndef SYNTHESIS
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == gflsu_pkg::ST_CLEAR |-> !accept)
      else $error("item accepted during clearing pass");

   a_clear_blocks_input: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_item_ff.op == gflsu_pkg::OP_CLEAR |-> !accept)
      else $error("item accepted behind a clear item");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_entry_found |-> rsp_entry_missing && rsp_entry_value == '0)
      else $error("empty group result not reported as missing zero");

   a_error_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_group_error |-> !rsp_entry_found)
      else $error("bad group reported as found");

   a_no_update_write_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == gflsu_pkg::ST_CLEAR |-> !s1_valid_ff || s1_item_ff.op == gflsu_pkg::OP_CLEAR
      || !upd_wr_en)
      else $error("update write pending during clearing pass");
`endif

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of grouped_first_last_select_unit
// Walks a directed table of items and register settings, then runs phases of
// random items under several settings, with random gaps and stalls on both
// channels. Results are checked against a predictor or the table's typed rows.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESET_CYCLES    = 5;
   localparam int SETTLE_CYCLES   = gflsu_pkg::MAX_GROUPS + 64;
   localparam int DRAIN_CYCLES    = 16;
   localparam int WATCHDOG_LIMIT  = 20000;
   localparam int HOLD_CYCLES     = 300;
   localparam int N_PHASES        = 8;
   localparam int ITEMS_PER_PHASE = 230;
   localparam int N_ROWS          = 23;

   // op code three is not in the enum; the block treats it as a read
   localparam logic [1:0] OP_SPARE = 2'b11;

   localparam logic [gflsu_pkg::VALUE_BITS-1:0] MIN_VAL  = 64'h8000_0000_0000_0000;
   localparam logic [gflsu_pkg::VALUE_BITS-1:0] MAX_VAL  = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [gflsu_pkg::VALUE_BITS-1:0] ALL_ONES = '1;

   localparam gflsu_pkg::rsp_type EMPTY_OK   = '{64'd0, 1'b1, 1'b0, 1'b0};
   localparam gflsu_pkg::rsp_type EMPTY_ERR  = '{64'd0, 1'b1, 1'b0, 1'b1};
   localparam gflsu_pkg::cfg_type NO_SETTING = '0;

   localparam gflsu_pkg::cfg_type FIXED_SETTINGS [4] = '{
      '{1'b0, 1'b0, gflsu_pkg::GROUPS_RESET},
      '{1'b1, 1'b0, gflsu_pkg::GROUPS_RESET},
      '{1'b0, 1'b1, 11'd1},
      '{1'b1, 1'b1, 11'd512}
   };

   typedef enum logic [1:0] {
      ROW_ITEM,   // item checked against the predictor
      ROW_TYPED,  // item with its result written in the table
      ROW_CFG     // register setting, written while idle
   } row_kind_type;

   typedef struct packed {
      row_kind_type                     kind;
      gflsu_pkg::cfg_type               setting;
      logic [1:0]                       op;
      logic [gflsu_pkg::GROUP_BITS-1:0] group;
      logic [gflsu_pkg::VALUE_BITS-1:0] value;
      logic                             missing;
      gflsu_pkg::rsp_type               want;
   } stim_row_type;

   // Directed items: extremes, every op, and the special cases
   localparam stim_row_type DIRECTED_ROWS [N_ROWS] = '{
      // empty after reset, then first occurrence at group zero
      '{ROW_TYPED, NO_SETTING, gflsu_pkg::OP_READ,  10'd0,    64'd0,    1'b0, EMPTY_OK},
      '{ROW_TYPED, NO_SETTING, gflsu_pkg::OP_ACCUM, 10'd0,    MIN_VAL,  1'b0,
        '{MIN_VAL, 1'b0, 1'b1, 1'b0}},
      '{ROW_TYPED, NO_SETTING, gflsu_pkg::OP_ACCUM, 10'd0,    MAX_VAL,  1'b0,
        '{MIN_VAL, 1'b0, 1'b1, 1'b0}},
      // missing value stored when not skipped, top group
      '{ROW_TYPED, NO_SETTING, gflsu_pkg::OP_ACCUM, 10'd1023, MAX_VAL,  1'b1,
        '{MAX_VAL, 1'b1, 1'b1, 1'b0}},
      '{ROW_TYPED, NO_SETTING, OP_SPARE,            10'd1023, 64'd0,    1'b0,
        '{MAX_VAL, 1'b1, 1'b1, 1'b0}},
      '{ROW_TYPED, NO_SETTING, gflsu_pkg::OP_ACCUM, 10'd1,    ALL_ONES, 1'b0,
        '{ALL_ONES, 1'b0, 1'b1, 1'b0}},
      // clear empties every group
      '{ROW_TYPED, NO_SETTING, gflsu_pkg::OP_CLEAR, 10'd1,    64'd0,    1'b0, EMPTY_OK},
      '{ROW_TYPED, NO_SETTING, gflsu_pkg::OP_READ,  10'd0,    64'd0,    1'b0, EMPTY_OK},
      // last mode, skip missing, four groups
      '{ROW_CFG,   '{1'b1, 1'b1, 11'd4},    gflsu_pkg::OP_READ, 10'd0, 64'd0, 1'b0,
        EMPTY_OK},
      '{ROW_TYPED, NO_SETTING, gflsu_pkg::OP_ACCUM, 10'd4,    64'd5,    1'b0, EMPTY_ERR},
      '{ROW_ITEM,  NO_SETTING, gflsu_pkg::OP_ACCUM, 10'd3,    64'h1234, 1'b0, EMPTY_OK},
      '{ROW_ITEM,  NO_SETTING, gflsu_pkg::OP_ACCUM, 10'd3,    64'hABCD, 1'b1, EMPTY_OK},
      '{ROW_ITEM,  NO_SETTING, gflsu_pkg::OP_ACCUM, 10'd3,    64'h5678, 1'b0, EMPTY_OK},
      '{ROW_TYPED, NO_SETTING, gflsu_pkg::OP_CLEAR, 10'd7,    64'd0,    1'b0, EMPTY_ERR},
      '{ROW_ITEM,  NO_SETTING, gflsu_pkg::OP_READ,  10'd3,    64'd0,    1'b0, EMPTY_OK},
      // no group in use: every index flagged
      '{ROW_CFG,   '{1'b0, 1'b0, 11'd0},    gflsu_pkg::OP_READ, 10'd0, 64'd0, 1'b0,
        EMPTY_OK},
      '{ROW_TYPED, NO_SETTING, gflsu_pkg::OP_ACCUM, 10'd0,    64'd9,    1'b0, EMPTY_ERR},
      '{ROW_TYPED, NO_SETTING, gflsu_pkg::OP_READ,  10'd0,    64'd0,    1'b0, EMPTY_ERR},
      // groups in use above the depth
      '{ROW_CFG,   '{1'b1, 1'b0, 11'd2047}, gflsu_pkg::OP_READ, 10'd0, 64'd0, 1'b0,
        EMPTY_OK},
      '{ROW_ITEM,  NO_SETTING, gflsu_pkg::OP_ACCUM, 10'd1023, 64'd1,    1'b1, EMPTY_OK},
      '{ROW_ITEM,  NO_SETTING, gflsu_pkg::OP_ACCUM, 10'd1023, 64'd2,    1'b1, EMPTY_OK},
      '{ROW_ITEM,  NO_SETTING, gflsu_pkg::OP_ACCUM, 10'd512,  MIN_VAL,  1'b0, EMPTY_OK},
      '{ROW_ITEM,  NO_SETTING, gflsu_pkg::OP_READ,  10'd1023, 64'd0,    1'b0, EMPTY_OK}
   };

   logic                             clock              = 1'b0;
   logic                             reset              = 1'b1;
   logic                             req_valid          = 1'b0;
   logic                             req_stall;
   logic [1:0]                       req_op             = gflsu_pkg::OP_READ;
   logic [gflsu_pkg::GROUP_BITS-1:0] req_group_index    = '0;
   logic [gflsu_pkg::VALUE_BITS-1:0] req_sample_value   = '0;
   logic                             req_sample_missing = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_stall          = 1'b0;
   logic [gflsu_pkg::VALUE_BITS-1:0] rsp_entry_value;
   logic                             rsp_entry_missing;
   logic                             rsp_entry_found;
   logic                             rsp_group_error;
   logic                             psel               = 1'b0;
   logic                             penable            = 1'b0;
   logic                             pwrite             = 1'b0;
   logic [gflsu_pkg::ADDR_BITS-1:0]  paddr              = '0;
   logic [gflsu_pkg::DATA_BITS-1:0]  pwdata             = '0;
   logic [gflsu_pkg::DATA_BITS-1:0]  prdata;
   logic                             pready;

   // Predictor state: entry copy and current register setting
   logic [gflsu_pkg::VALUE_BITS-1:0] stored_value   [gflsu_pkg::MAX_GROUPS] = '{default: '0};
   logic                             stored_missing [gflsu_pkg::MAX_GROUPS] = '{default: 1'b0};
   logic                             stored_found   [gflsu_pkg::MAX_GROUPS] = '{default: 1'b0};
   gflsu_pkg::cfg_type               cfg_now = '{1'b0, 1'b0, gflsu_pkg::GROUPS_RESET};

   gflsu_pkg::rsp_type expected_entries [$];
   int                 mismatch_count   = 0;
   int                 idle_cycles      = 0;
   int                 long_hold_cycles = 0;
   logic               idle_send        = 1'b1;
   logic               idle_recv        = 1'b1;

   grouped_first_last_select_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_group_index    (req_group_index),
      .req_sample_value   (req_sample_value),
      .req_sample_missing (req_sample_missing),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_entry_value    (rsp_entry_value),
      .rsp_entry_missing  (rsp_entry_missing),
      .rsp_entry_found    (rsp_entry_found),
      .rsp_group_error    (rsp_group_error),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Update the entry copy for one item and return the entry it reports
   function automatic gflsu_pkg::rsp_type predict_entry(input gflsu_pkg::item_type it);
      gflsu_pkg::rsp_type r;
      logic               err;
      err = {1'b0, it.group_index} >= cfg_now.groups_in_use;
      if (it.op == gflsu_pkg::OP_CLEAR) begin
         foreach (stored_found[g]) stored_found[g] = 1'b0;
      end else if (it.op == gflsu_pkg::OP_ACCUM && !err
                   && !(cfg_now.skip_missing && it.sample_missing)
                   && (cfg_now.select_last || !stored_found[it.group_index])) begin
         stored_value[it.group_index]   = it.sample_value;
         stored_missing[it.group_index] = it.sample_missing;
         stored_found[it.group_index]   = 1'b1;
      end
      r.group_error = err;
      if (err || !stored_found[it.group_index]) begin
         r.entry_value   = '0;
         r.entry_missing = 1'b1;
         r.entry_found   = 1'b0;
      end else begin
         r.entry_value   = stored_value[it.group_index];
         r.entry_missing = stored_missing[it.group_index];
         r.entry_found   = 1'b1;
      end
      return r;
   endfunction

   task automatic check_field(input string name,
                              input logic [gflsu_pkg::VALUE_BITS-1:0] want,
                              input logic [gflsu_pkg::VALUE_BITS-1:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         mismatch_count++;
      end
   endtask

   // Offer one item after a random gap; record its expected entry on acceptance
   task automatic send_item(input gflsu_pkg::item_type it, input logic typed,
                            input gflsu_pkg::rsp_type want);
      int                 gap;
      gflsu_pkg::rsp_type predicted;
      gap = idle_send ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_op             <= it.op;
      req_group_index    <= it.group_index;
      req_sample_value   <= it.sample_value;
      req_sample_missing <= it.sample_missing;
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted = predict_entry(it);
      expected_entries.push_back(typed ? want : predicted);
   endtask

   // Setup cycle, then access cycle; psel stays high for a following write
   task automatic write_register(input gflsu_pkg::reg_index_type index,
                                 input logic [gflsu_pkg::DATA_BITS-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
   endtask

   // Drain, let any clearing pass finish, then write all three registers
   task automatic apply_setting(input gflsu_pkg::cfg_type s);
      req_valid <= 1'b0;
      while (expected_entries.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_register(gflsu_pkg::REG_SELECT_LAST, gflsu_pkg::DATA_BITS'(s.select_last));
      write_register(gflsu_pkg::REG_SKIP_MISSING, gflsu_pkg::DATA_BITS'(s.skip_missing));
      write_register(gflsu_pkg::REG_GROUPS_IN_USE, gflsu_pkg::DATA_BITS'(s.groups_in_use));
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      cfg_now  = s;
   endtask

   // Result side: stall at random, hold off long when asked, check each item
   initial begin
      int                 hold;
      gflsu_pkg::rsp_type want;
      wait (reset == 1'b0);
      forever begin
         hold = idle_recv ? $urandom_range(0, 15) : 0;
         if (long_hold_cycles > 0) begin
            hold             = long_hold_cycles;
            long_hold_cycles = 0;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         if (expected_entries.size() == 0) begin
            $error("result item with no expected entry waiting");
            mismatch_count++;
         end else begin
            want = expected_entries.pop_front();
            check_field("entry_value", want.entry_value, rsp_entry_value);
            check_field("entry_missing", want.entry_missing, rsp_entry_missing);
            check_field("entry_found", want.entry_found, rsp_entry_found);
            check_field("group_error", want.group_error, rsp_group_error);
         end
      end
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_valid === 1'b1 && req_stall === 1'b0)
          || (rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("FAIL grouped_first_last_select_unit");
         $finish;
      end
   end

   // Stimulus: directed table, then random phases
   initial begin
      gflsu_pkg::item_type it;
      gflsu_pkg::cfg_type  setting;
      int                  pick;
      int                  near;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[r]) begin
         if (DIRECTED_ROWS[r].kind == ROW_CFG) begin
            apply_setting(DIRECTED_ROWS[r].setting);
         end else begin
            it.op             = DIRECTED_ROWS[r].op;
            it.group_index    = DIRECTED_ROWS[r].group;
            it.sample_value   = DIRECTED_ROWS[r].value;
            it.sample_missing = DIRECTED_ROWS[r].missing;
            send_item(it, DIRECTED_ROWS[r].kind == ROW_TYPED, DIRECTED_ROWS[r].want);
         end
      end

      for (int phase = 0; phase < N_PHASES; phase++) begin
         if (phase < 4) begin
            setting = FIXED_SETTINGS[phase];
         end else begin
            setting.select_last   = 1'($urandom_range(0, 1));
            setting.skip_missing  = 1'($urandom_range(0, 1));
            setting.groups_in_use = ($urandom_range(0, 2) == 0) ? gflsu_pkg::GROUPS_RESET
               : gflsu_pkg::COUNT_BITS'($urandom_range(1, gflsu_pkg::MAX_GROUPS));
         end
         apply_setting(setting);
         // fill the block behind a long result stall
         if (phase == 0) long_hold_cycles = HOLD_CYCLES;

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n % 40 == 0) begin
               idle_send = ($urandom_range(0, 3) != 0);
               idle_recv = ($urandom_range(0, 3) != 0);
            end
            if (phase == 0 && n < 80) idle_send = 1'b0;

            // mostly accumulate, some reads, rare clears
            pick = $urandom_range(0, 99);
            if (pick == 99) it.op = gflsu_pkg::OP_CLEAR;
            else if (pick >= 96) it.op = OP_SPARE;
            else if (pick >= 72) it.op = gflsu_pkg::OP_READ;
            else it.op = gflsu_pkg::OP_ACCUM;

            // a few busy groups, the in-use boundary, or anywhere
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
               it.group_index = gflsu_pkg::GROUP_BITS'($urandom_range(0, 7));
            end else if (pick < 80) begin
               near = int'(cfg_now.groups_in_use) + int'($urandom_range(0, 7)) - 4;
               if (near < 0) near = 0;
               if (near > gflsu_pkg::MAX_GROUPS - 1) near = gflsu_pkg::MAX_GROUPS - 1;
               it.group_index = gflsu_pkg::GROUP_BITS'(near);
            end else begin
               it.group_index = gflsu_pkg::GROUP_BITS'($urandom());
            end

            pick = $urandom_range(0, 9);
            if (pick < 5) it.sample_value = gflsu_pkg::VALUE_BITS'($urandom_range(0, 15));
            else if (pick == 5) it.sample_value = MIN_VAL;
            else if (pick == 6) it.sample_value = MAX_VAL;
            else it.sample_value = {$urandom(), $urandom()};
            it.sample_missing = ($urandom_range(0, 3) == 0);

            send_item(it, 1'b0, EMPTY_OK);
         end
      end

      // drain and wait out the pipeline
      req_valid <= 1'b0;
      idle_recv  = 1'b0;
      while (expected_entries.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS grouped_first_last_select_unit");
      end else begin
         $display("FAIL grouped_first_last_select_unit");
      end
      $finish;
   end

endmodule
